FILE: design/tilemap_word_decompressor_core_defines.svh
// Assertion macros shared by the tilemap word decompressor RTL
`ifndef TILEMAP_WORD_DECOMPRESSOR_CORE_DEFINES_SVH
`define TILEMAP_WORD_DECOMPRESSOR_CORE_DEFINES_SVH

// cond must never hold outside reset
`define TWD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("twd: forbidden condition seen");

// ante implies cons in the same cycle
`define TWD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twd: implication failed");

`endif

FILE: design/twd_pkg.sv
// Types and constants for the tilemap word decompressor
package twd_pkg;

    localparam int BufDepth = 32;
    localparam int BufAw    = 5;
    localparam int CntW     = 6;

    // packet kinds
    localparam logic [2:0] KindFlat   = 3'd0;
    localparam logic [2:0] KindUp     = 3'd1;
    localparam logic [2:0] KindDown   = 3'd2;
    localparam logic [2:0] KindList   = 3'd3;
    localparam logic [2:0] KindIncRun = 3'd4;
    localparam logic [2:0] KindCommon = 3'd5;

    // header byte positions
    localparam logic [2:0] HdrLength  = 3'd0;
    localparam logic [2:0] HdrMask    = 3'd1;
    localparam logic [2:0] HdrIncHi   = 3'd2;
    localparam logic [2:0] HdrIncLo   = 3'd3;
    localparam logic [2:0] HdrComHi   = 3'd4;
    localparam logic [2:0] HdrComLo   = 3'd5;
    localparam logic [2:0] HdrBytes   = 3'd6;

    localparam logic [4:0] MaxValueLen = 5'd16;
    localparam logic [3:0] EndCount    = 4'hF;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_RUNSEL,
        PH_MODE,
        PH_COUNT,
        PH_MASK,
        PH_VALUE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_SETTLE,
        S_RUN,
        S_FINISH,
        S_DRAIN
    } seq_state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    // sequencer to word buffer
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_word;
        logic        clear;
        logic        drain;
        logic        done;
    } buf_ctrl_t;

    // word buffer to sequencer
    typedef struct packed {
        logic            draining;
        logic [CntW-1:0] count;
    } buf_stat_t;

endpackage

FILE: design/twd_alu.sv
// Shared 16-bit adder: add, increment, decrement
module twd_alu
    import twd_pkg::*;
(
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  alu_op_t     op,
    output logic [15:0] y
);

    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_INC: y = a + 16'd1;
            ALU_DEC: y = a - 16'd1;
            default: y = a;
        endcase
    end

endmodule

FILE: design/twd_seq.sv
// Header parser and bit-serial packet sequencer
module twd_seq
    import twd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    output buf_ctrl_t  ctrl,
    input  buf_stat_t  stat
);

    seq_state_t  state_reg, state_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [4:0]  value_length_reg, value_length_next;
    logic [4:0]  flag_mask_reg, flag_mask_next;
    logic [15:0] running_word_reg, running_word_next;
    logic [15:0] repeat_word_reg, repeat_word_next;
    phase_t      parse_phase_reg, parse_phase_next;
    logic [2:0]  packet_kind_reg, packet_kind_next;
    logic [3:0]  run_left_reg, run_left_next;
    logic [15:0] work_value_reg, work_value_next;
    logic [4:0]  field_bit_count_reg, field_bit_count_next;
    logic        end_seen_reg, end_seen_next;
    logic [7:0]  byte_reg, byte_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;

    logic [15:0] alu_a, alu_b, alu_y;
    alu_op_t     alu_op;

    twd_alu u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            header_index_reg    <= '0;
            value_length_reg    <= '0;
            flag_mask_reg       <= '0;
            running_word_reg    <= '0;
            repeat_word_reg     <= '0;
            parse_phase_reg     <= PH_FLAG;
            packet_kind_reg     <= '0;
            run_left_reg        <= '0;
            work_value_reg      <= '0;
            field_bit_count_reg <= '0;
            end_seen_reg        <= 1'b0;
            byte_reg            <= '0;
            bit_cnt_reg         <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            header_index_reg    <= header_index_next;
            value_length_reg    <= value_length_next;
            flag_mask_reg       <= flag_mask_next;
            running_word_reg    <= running_word_next;
            repeat_word_reg     <= repeat_word_next;
            parse_phase_reg     <= parse_phase_next;
            packet_kind_reg     <= packet_kind_next;
            run_left_reg        <= run_left_next;
            work_value_reg      <= work_value_next;
            field_bit_count_reg <= field_bit_count_next;
            end_seen_reg        <= end_seen_next;
            byte_reg            <= byte_next;
            bit_cnt_reg         <= bit_cnt_next;
        end
    end

    // next state and outputs
    always_comb
    begin
        logic       bit_v;
        logic       resume;
        logic [4:0] vpos;
        logic [3:0] pos;
        logic [2:0] midx;

        state_next           = state_reg;
        header_index_next    = header_index_reg;
        value_length_next    = value_length_reg;
        flag_mask_next       = flag_mask_reg;
        running_word_next    = running_word_reg;
        repeat_word_next     = repeat_word_reg;
        parse_phase_next     = parse_phase_reg;
        packet_kind_next     = packet_kind_reg;
        run_left_next        = run_left_reg;
        work_value_next      = work_value_reg;
        field_bit_count_next = field_bit_count_reg;
        end_seen_next        = end_seen_reg;
        byte_next            = byte_reg;
        bit_cnt_next         = bit_cnt_reg;

        bit_v  = byte_reg[7];
        resume = 1'b0;
        vpos   = value_length_reg - 5'd1 - field_bit_count_reg;
        pos    = 4'd0;
        midx   = 3'd4 - field_bit_count_reg[2:0];

        alu_a  = work_value_reg;
        alu_b  = 16'd0;
        alu_op = ALU_ADD;

        s_tready      = 1'b0;
        ctrl.wr_en    = 1'b0;
        ctrl.wr_word  = work_value_reg;
        ctrl.clear    = 1'b0;
        ctrl.drain    = 1'b0;
        ctrl.done     = end_seen_reg;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.clear = 1'b1;
                    // start mark restarts the whole stream
                    if (s_tuser[0])
                    begin
                        header_index_next    = '0;
                        value_length_next    = '0;
                        flag_mask_next       = '0;
                        running_word_next    = '0;
                        repeat_word_next     = '0;
                        parse_phase_next     = PH_FLAG;
                        packet_kind_next     = '0;
                        run_left_next        = '0;
                        work_value_next      = '0;
                        field_bit_count_next = '0;
                        end_seen_next        = 1'b0;
                    end
                    if (!end_seen_next)
                    begin
                        if (header_index_next < HdrBytes)
                        begin
                            case (header_index_next)
                                HdrLength:
                                    value_length_next = (s_tdata > 8'(MaxValueLen)) ?
                                        MaxValueLen : s_tdata[4:0];
                                HdrMask:  flag_mask_next = s_tdata[4:0];
                                HdrIncHi: running_word_next[15:8] = s_tdata;
                                HdrIncLo: running_word_next[7:0]  = s_tdata;
                                HdrComHi: repeat_word_next[15:8]  = s_tdata;
                                default:  repeat_word_next[7:0]   = s_tdata;
                            endcase
                            header_index_next = header_index_next + 3'd1;
                            if (header_index_next == HdrBytes)
                            begin
                                parse_phase_next     = PH_FLAG;
                                field_bit_count_next = '0;
                                work_value_next      = '0;
                            end
                        end
                        else
                        begin
                            byte_next    = s_tdata;
                            bit_cnt_next = 4'd8;
                            state_next   = S_BIT;
                        end
                    end
                end
            end

            S_BIT:
            begin
                byte_next    = {byte_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 4'd1;
                resume       = 1'b1;
                case (parse_phase_reg)
                    PH_FLAG:
                    begin
                        work_value_next      = '0;
                        field_bit_count_next = '0;
                        parse_phase_next     = bit_v ? PH_MODE : PH_RUNSEL;
                    end
                    PH_RUNSEL:
                    begin
                        packet_kind_next     = bit_v ? KindCommon : KindIncRun;
                        work_value_next      = '0;
                        field_bit_count_next = '0;
                        parse_phase_next     = PH_COUNT;
                    end
                    PH_MODE:
                    begin
                        work_value_next      = {14'd0, work_value_reg[0], bit_v};
                        field_bit_count_next = field_bit_count_reg + 5'd1;
                        if (field_bit_count_next >= 5'd2)
                        begin
                            packet_kind_next     = {1'b0, work_value_reg[0], bit_v};
                            work_value_next      = '0;
                            field_bit_count_next = '0;
                            parse_phase_next     = PH_COUNT;
                        end
                    end
                    PH_COUNT:
                    begin
                        work_value_next      = {12'd0, work_value_reg[2:0], bit_v};
                        field_bit_count_next = field_bit_count_reg + 5'd1;
                        if (field_bit_count_next >= 5'd4)
                        begin
                            run_left_next        = {work_value_reg[2:0], bit_v};
                            work_value_next      = '0;
                            field_bit_count_next = '0;
                            if (packet_kind_reg == KindIncRun ||
                                packet_kind_reg == KindCommon)
                            begin
                                parse_phase_next = PH_FLAG;
                                state_next       = S_RUN;
                                resume           = 1'b0;
                            end
                            else if (packet_kind_reg == KindList &&
                                     run_left_next == EndCount)
                            begin
                                end_seen_next    = 1'b1;
                                parse_phase_next = PH_FLAG;
                            end
                            else
                            begin
                                parse_phase_next = PH_MASK;
                                state_next       = S_SETTLE;
                                resume           = 1'b0;
                            end
                        end
                    end
                    PH_MASK, PH_VALUE:
                    begin
                        // place one bit of the inline value
                        pos = (parse_phase_reg == PH_MASK) ?
                            (4'd15 - field_bit_count_reg[3:0]) : vpos[3:0];
                        alu_a  = work_value_reg;
                        alu_b  = 16'(bit_v) << pos;
                        alu_op = ALU_ADD;
                        work_value_next      = alu_y;
                        field_bit_count_next = field_bit_count_reg + 5'd1;
                        state_next           = S_SETTLE;
                        resume               = 1'b0;
                    end
                    default:
                        parse_phase_next = PH_FLAG;
                endcase
            end

            S_SETTLE:
            begin
                case (parse_phase_reg)
                    PH_MASK:
                    begin
                        if (field_bit_count_reg >= 5'd5)
                        begin
                            parse_phase_next     = PH_VALUE;
                            field_bit_count_next = '0;
                        end
                        else if (!flag_mask_reg[midx])
                            field_bit_count_next = field_bit_count_reg + 5'd1;
                        else
                            resume = 1'b1;
                    end
                    PH_VALUE:
                    begin
                        if (field_bit_count_reg >= value_length_reg)
                        begin
                            if (packet_kind_reg < KindList)
                            begin
                                parse_phase_next = PH_FLAG;
                                state_next       = S_RUN;
                            end
                            else
                            begin
                                ctrl.wr_en   = 1'b1;
                                ctrl.wr_word = work_value_reg;
                                if (run_left_reg == 4'd0)
                                begin
                                    parse_phase_next = PH_FLAG;
                                    resume           = 1'b1;
                                end
                                else
                                begin
                                    run_left_next        = run_left_reg - 4'd1;
                                    work_value_next      = '0;
                                    field_bit_count_next = '0;
                                    parse_phase_next     = PH_MASK;
                                end
                            end
                        end
                        else
                            resume = 1'b1;
                    end
                    default:
                        resume = 1'b1;
                endcase
            end

            S_RUN:
            begin
                ctrl.wr_en = 1'b1;
                case (packet_kind_reg)
                    KindIncRun:
                    begin
                        ctrl.wr_word      = running_word_reg;
                        alu_a             = running_word_reg;
                        alu_op            = ALU_INC;
                        running_word_next = alu_y;
                    end
                    KindCommon:
                        ctrl.wr_word = repeat_word_reg;
                    KindUp:
                    begin
                        alu_op          = ALU_INC;
                        work_value_next = alu_y;
                    end
                    KindDown:
                    begin
                        alu_op          = ALU_DEC;
                        work_value_next = alu_y;
                    end
                    default:
                        ctrl.wr_word = work_value_reg;
                endcase
                if (run_left_reg == 4'd0)
                    resume = 1'b1;
                else
                    run_left_next = run_left_reg - 4'd1;
            end

            S_FINISH:
            begin
                if (stat.count != '0)
                begin
                    ctrl.drain = 1'b1;
                    state_next = S_DRAIN;
                end
                else
                    state_next = S_IDLE;
            end

            S_DRAIN:
            begin
                if (!stat.draining)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase

        // go on with the next bit, or close the byte
        if (resume)
            state_next = (bit_cnt_next != 4'd0 && !end_seen_next) ? S_BIT : S_FINISH;
    end

endmodule

FILE: design/twd_word_buf.sv
// Word buffer for one byte's results and the output register
module twd_word_buf
    import twd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  buf_ctrl_t   ctrl,
    output buf_stat_t   stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_word
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] stream_done
);

    logic [15:0]     mem [BufDepth];
    logic [CntW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CntW-1:0] rd_ptr_reg, rd_ptr_next;
    logic            draining_reg, draining_next;
    logic            done_reg, done_next;
    logic            valid_reg, valid_next;
    logic            load;
    logic            is_last;
    logic [15:0]     word_reg;
    logic            last_reg;
    logic            sdone_reg;

    assign load    = draining_reg && (!valid_reg || m_tready);
    assign is_last = (rd_ptr_reg + CntW'(1)) == wr_ptr_reg;

    // pointers and flags
    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        draining_next = draining_reg;
        done_next     = done_reg;
        valid_next    = valid_reg;

        if (ctrl.clear)
            wr_ptr_next = '0;
        else if (ctrl.wr_en && wr_ptr_reg < CntW'(BufDepth))
            wr_ptr_next = wr_ptr_reg + CntW'(1);

        if (ctrl.drain)
        begin
            draining_next = 1'b1;
            rd_ptr_next   = '0;
            done_next     = ctrl.done;
        end

        if (load)
        begin
            valid_next  = 1'b1;
            rd_ptr_next = rd_ptr_reg + CntW'(1);
            if (is_last)
                draining_next = 1'b0;
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            draining_reg <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            draining_reg <= draining_next;
            done_reg     <= done_next;
            valid_reg    <= valid_next;
        end
    end

    // storage, words beyond the depth are dropped
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && !ctrl.clear && wr_ptr_reg < CntW'(BufDepth))
            mem[wr_ptr_reg[BufAw-1:0]] <= ctrl.wr_word;
    end

    // registered read into the output stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg  <= mem[rd_ptr_reg[BufAw-1:0]];
            last_reg  <= is_last;
            sdone_reg <= done_reg;
        end
    end

    assign stat.draining = draining_reg;
    assign stat.count    = wr_ptr_reg;
    assign m_tvalid      = valid_reg;
    assign m_tdata       = word_reg;
    assign m_tlast       = last_reg;
    assign m_tuser       = sdone_reg;

endmodule

FILE: design/tilemap_word_decompressor_core.sv
// Top level of the tilemap word decompressor
//
//  channel | dir | tdata         | tuser             | tlast
//  s_*     | in  | [7:0] byte    | [0] stream start  | -
//  m_*     | out | [15:0] word   | [0] stream done   | last word of the byte
//
// Header bytes and ignored bytes are taken in S_IDLE. A packet byte is walked
// bit by bit in S_BIT, with S_RUN writing each word of a run, S_SETTLE placing
// each inline value and S_FINISH closing the byte; a byte that made words then
// drains one word per cycle at the output pace before S_IDLE is entered again.
// All words of a byte are collected in a 32-entry buffer before the first is
// shown, since the done flag is known only at the end of the byte.
// Reset is asynchronous, active low; the byte input stalls until the drain ends.
`include "tilemap_word_decompressor_core_defines.svh"

module tilemap_word_decompressor_core
    import twd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] start_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_word
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] stream_done
);

    buf_ctrl_t ctrl;
    buf_stat_t stat;

    twd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    twd_word_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // checks
    `TWD_ASSERT_NEVER(a_no_accept_while_drain, s_tready && stat.draining)
    `TWD_ASSERT_NEVER(a_count_in_range, stat.count > CntW'(BufDepth))
    `TWD_ASSERT_IMPL(a_drain_ends_on_last, $fell(stat.draining), m_tvalid && m_tlast)

endmodule
